>>> rtl/cma_pkg.sv
// Shared types and constants of the centred moving average block.
`default_nettype none

package cma_pkg;

    // Control word that travels with every request through both cell chains
    typedef struct packed {
        logic valid;
        logic last;
        logic neg;
    } cma_ctl_t;

    localparam int          CFG_W           = 6;
    localparam logic [5:0]  WINDOW_RESET    = 6'd1;
    localparam int          APB_AW          = 3;
    localparam int          APB_DW          = 32;
    localparam logic        REG_WINDOW_SIZE = 1'b0;

endpackage

`default_nettype wire

>>> rtl/cma_in_if.sv
// Sample input channel: valid/ready handshake with sample and block end flag.
`default_nettype none

interface cma_in_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          block_end;

    modport source (output valid, output sample, output block_end, input ready);
    modport sink   (input valid, input sample, input block_end, output ready);
endinterface

`default_nettype wire

>>> rtl/cma_out_if.sv
// Average output channel: valid/ready handshake with average and block last flag.
`default_nettype none

interface cma_out_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          block_last;

    modport source (output valid, output average, output block_last, input ready);
    modport sink   (input valid, input average, input block_last, output ready);
endinterface

`default_nettype wire

>>> rtl/cma_sum_cell.sv
// Accumulation cell: one history tap plus one stage of the window-sum chain.
`default_nettype none

module cma_sum_cell #(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_HALF    = 16,
    parameter int IDX         = 0,
    localparam int DEPTH      = 2 * MAX_HALF + 1,
    localparam int SEEN_W     = $clog2(DEPTH + 1),
    localparam int O_W        = $clog2(MAX_HALF + 1),
    localparam int SUM_W      = SAMPLE_BITS + $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          shift_en,
    input  wire logic                          adv,
    input  wire logic signed [SAMPLE_BITS-1:0] hist_in,
    output logic signed [SAMPLE_BITS-1:0]      hist_out,
    input  wire logic [SEEN_W-1:0]             seen,
    input  wire logic signed [SAMPLE_BITS-1:0] first,
    input  wire logic [O_W-1:0]                half,
    input  wire cma_pkg::cma_ctl_t             ctl_in,
    input  wire logic [O_W-1:0]                o_in,
    input  wire logic signed [SUM_W-1:0]       sum_in,
    output cma_pkg::cma_ctl_t                  ctl_out,
    output logic [O_W-1:0]                     o_out,
    output logic signed [SUM_W-1:0]            sum_out
);

    localparam int              CW    = SEEN_W + 1;
    localparam logic [CW-1:0]   IDX_C = CW'(IDX);

    logic signed [SAMPLE_BITS-1:0] hist_reg;
    cma_pkg::cma_ctl_t             ctl_reg;
    logic [O_W-1:0]                o_reg;
    logic signed [SUM_W-1:0]       sum_reg;

    logic                          in_win;
    logic                          live;
    logic signed [SAMPLE_BITS-1:0] term;
    logic signed [SUM_W-1:0]       sum_next;

    // tap lies inside o-half .. o+half
    assign in_win   = (IDX_C + CW'(half) >= CW'(o_in)) && (IDX_C <= CW'(o_in) + CW'(half));
    // taps older than the block start replicate the first sample
    assign live     = IDX_C < CW'(seen);
    assign term     = live ? hist_reg : first;
    assign sum_next = in_win ? (sum_in + SUM_W'(term)) : sum_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_reg   <= o_in;
            sum_reg <= sum_next;
        end
        if (shift_en)
        begin
            hist_reg <= hist_in;
        end
    end

    assign hist_out = hist_reg;
    assign ctl_out  = ctl_reg;
    assign o_out    = o_reg;
    assign sum_out  = sum_reg;

endmodule

`default_nettype wire

>>> rtl/cma_div_cell.sv
// Divider cell: one restoring step, one quotient bit of the magnitude.
`default_nettype none

module cma_div_cell #(
    parameter int MAG_W = 29,
    parameter int DIV_W = 6
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic [DIV_W-1:0]   divisor,
    input  wire cma_pkg::cma_ctl_t  ctl_in,
    input  wire logic [DIV_W-1:0]   rem_in,
    input  wire logic [MAG_W-1:0]   mq_in,
    output cma_pkg::cma_ctl_t       ctl_out,
    output logic [DIV_W-1:0]        rem_out,
    output logic [MAG_W-1:0]        mq_out
);

    cma_pkg::cma_ctl_t  ctl_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [MAG_W-1:0]   mq_reg;

    logic [DIV_W:0]     trial;
    logic               qbit;
    logic [DIV_W-1:0]   rem_next;
    logic [MAG_W-1:0]   mq_next;

    // mq holds the unused dividend bits on top and the quotient bits below
    assign trial    = {rem_in, mq_in[MAG_W-1]};
    assign qbit     = trial >= {1'b0, divisor};
    assign rem_next = qbit ? DIV_W'(trial - {1'b0, divisor}) : DIV_W'(trial);
    assign mq_next  = {mq_in[MAG_W-2:0], qbit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg <= rem_next;
            mq_reg  <= mq_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign mq_out  = mq_reg;

endmodule

`default_nettype wire

>>> rtl/centered_moving_average_edge_replicate.sv
// Top level: centred moving average with edge replication over sample blocks.
//
//  channel     | dir | handshake              | payload
//  ------------+-----+------------------------+----------------------------------
//  sample_ch   | in  | valid / ready          | sample (signed), block_end
//  average_ch  | out | valid / ready          | average (signed, saturated), block_last
//  APB         | in  | psel, penable, pready  | paddr[2:0], pwdata, prdata (window_size)
//
//  An accepted sample shifts the history chain at once. If it produces requests
//  (one mid-block, up to MAX_HALF+1 on block_end) they enter the accumulation
//  chain one a cycle unless average_ch stalls, and the next sample is taken
//  once the last of them has left that chain; a sample that produces none
//  leaves sample_ch ready. The chain must drain before the history moves
//  again. Results pass the accumulation cells, the divider cells and the
//  output register, one a cycle; a stalled average_ch freezes both chains.
//  Reset is asynchronous and clears control state only; history taps need no clearing.
`default_nettype none

module centered_moving_average_edge_replicate #(
    parameter int MAX_HALF    = 16,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    cma_in_if.sink                                sample_ch,
    cma_out_if.source                             average_ch,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [cma_pkg::APB_AW-1:0]       paddr,
    input  wire logic [cma_pkg::APB_DW-1:0]       pwdata,
    output logic [cma_pkg::APB_DW-1:0]            prdata,
    output logic                                  pready
);

    localparam int DEPTH  = 2 * MAX_HALF + 1;
    localparam int SEEN_W = $clog2(DEPTH + 1);
    localparam int O_W    = $clog2(MAX_HALF + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(DEPTH);
    localparam int MAG_W  = SUM_W - 1;
    localparam int CMP_W  = (SEEN_W > cma_pkg::CFG_W) ? SEEN_W : cma_pkg::CFG_W;
    localparam int SB     = SAMPLE_BITS;

    localparam logic [SEEN_W-1:0] DEPTH_C  = SEEN_W'(DEPTH);
    localparam logic [MAG_W-1:0]  POS_LIM  = MAG_W'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic [MAG_W-1:0]  NEG_LIM  = MAG_W'(64'd1 << (SB - 1));
    localparam logic [SB-1:0]     SAT_MIN  = {1'b1, {(SB - 1){1'b0}}};
    localparam logic [SB-1:0]     SAT_MAX  = {1'b0, {(SB - 1){1'b1}}};

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LAUNCH = 2'b10
    } seq_state_t;

    // ---------------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------------
    logic [cma_pkg::CFG_W-1:0] ws_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == cma_pkg::REG_WINDOW_SIZE);
    assign prdata = (paddr[2] == cma_pkg::REG_WINDOW_SIZE) ?
                    cma_pkg::APB_DW'(ws_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= cma_pkg::WINDOW_RESET;
        end
        else if (cfg_wr)
        begin
            ws_reg <= pwdata[cma_pkg::CFG_W-1:0];
        end
    end

    // Effective divisor: 1 for pass-through, clamped to the history depth.
    // Pass-through then falls out of the general path with half = 0.
    logic [CMP_W-1:0]  ws_x;
    logic [CMP_W-1:0]  eff_x;
    logic [SEEN_W-1:0] divisor;
    logic [O_W-1:0]    half;

    assign ws_x    = CMP_W'(ws_reg);
    assign eff_x   = (ws_x <= CMP_W'(1)) ? CMP_W'(1) :
                     ((ws_x > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : ws_x);
    assign divisor = SEEN_W'(eff_x);
    assign half    = O_W'(divisor >> 1);

    // ---------------------------------------------------------------------
    // Block tracking and request sequencer
    // ---------------------------------------------------------------------
    seq_state_t                    state_reg, state_next;
    logic [O_W-1:0]                o_reg, o_next;
    logic                          flush_reg, flush_next;
    logic                          in_block_reg;
    logic [SEEN_W-1:0]             seen_reg;
    logic signed [SB-1:0]          first_reg;

    logic                          accept;
    logic                          adv;
    logic                          chain_busy;
    logic [SEEN_W-1:0]             seen_base;
    logic [SEEN_W-1:0]             seen_new;
    logic [SEEN_W-1:0]             seen_m1;
    logic [O_W-1:0]                top_o;

    assign sample_ch.ready = (state_reg == ST_IDLE) && !chain_busy;
    assign accept          = sample_ch.valid && sample_ch.ready;
    assign adv             = !average_ch.valid || average_ch.ready;

    // seen count restarts with the first sample after a block end
    assign seen_base = in_block_reg ? seen_reg : '0;
    assign seen_new  = (seen_base == DEPTH_C) ? DEPTH_C : seen_base + SEEN_W'(1);
    assign seen_m1   = seen_new - SEEN_W'(1);
    assign top_o     = (seen_m1 < SEEN_W'(half)) ? O_W'(seen_m1) : half;

    always_comb
    begin
        state_next = state_reg;
        o_next     = o_reg;
        flush_next = flush_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sample_ch.block_end)
                    begin
                        // flush: centres top_o .. 0 behind the newest sample
                        flush_next = 1'b1;
                        o_next     = top_o;
                        state_next = ST_LAUNCH;
                    end
                    else if (seen_new > SEEN_W'(half))
                    begin
                        flush_next = 1'b0;
                        o_next     = half;
                        state_next = ST_LAUNCH;
                    end
                end
            end
            ST_LAUNCH:
            begin
                if (adv)
                begin
                    if (flush_reg && (o_reg != '0))
                    begin
                        o_next = o_reg - O_W'(1);
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_block_reg <= 1'b0;
            seen_reg     <= '0;
            flush_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
            if (accept)
            begin
                in_block_reg <= !sample_ch.block_end;
                seen_reg     <= seen_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        o_reg <= o_next;
        if (accept && !in_block_reg)
        begin
            first_reg <= sample_ch.sample;
        end
    end

    // ---------------------------------------------------------------------
    // Accumulation chain: history taps, window sum built tap by tap
    // ---------------------------------------------------------------------
    logic signed [SB-1:0]    hist_link [DEPTH+1];
    cma_pkg::cma_ctl_t       sc_ctl    [DEPTH+1];
    logic [O_W-1:0]          sc_o      [DEPTH+1];
    logic signed [SUM_W-1:0] sc_sum    [DEPTH+1];
    logic [DEPTH-1:0]        busy_vec;

    // Positions newer than the newest sample replicate it: (half - o) copies
    logic [O_W-1:0]          pre_cnt;
    logic signed [SB+O_W:0]  pre_prod;

    assign pre_cnt  = half - o_reg;
    assign pre_prod = $signed(hist_link[1]) * $signed({1'b0, pre_cnt});

    assign hist_link[0]     = sample_ch.sample;
    assign sc_ctl[0].valid  = (state_reg == ST_LAUNCH);
    assign sc_ctl[0].last   = flush_reg && (o_reg == '0);
    assign sc_ctl[0].neg    = 1'b0;
    assign sc_o[0]          = o_reg;
    assign sc_sum[0]        = SUM_W'(pre_prod);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_sum
            cma_sum_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .MAX_HALF    (MAX_HALF),
                .IDX         (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (accept),
                .adv      (adv),
                .hist_in  (hist_link[gi]),
                .hist_out (hist_link[gi+1]),
                .seen     (seen_reg),
                .first    (first_reg),
                .half     (half),
                .ctl_in   (sc_ctl[gi]),
                .o_in     (sc_o[gi]),
                .sum_in   (sc_sum[gi]),
                .ctl_out  (sc_ctl[gi+1]),
                .o_out    (sc_o[gi+1]),
                .sum_out  (sc_sum[gi+1])
            );
            assign busy_vec[gi] = sc_ctl[gi+1].valid;
        end
    endgenerate

    assign chain_busy = |busy_vec;

    // ---------------------------------------------------------------------
    // Divider chain: sign-magnitude restoring division, truncates to zero
    // ---------------------------------------------------------------------
    cma_pkg::cma_ctl_t       dv_ctl [MAG_W+1];
    logic [SEEN_W-1:0]       dv_rem [MAG_W+1];
    logic [MAG_W-1:0]        dv_mq  [MAG_W+1];
    logic                    sum_neg;

    assign sum_neg         = sc_sum[DEPTH][SUM_W-1];
    assign dv_ctl[0].valid = sc_ctl[DEPTH].valid;
    assign dv_ctl[0].last  = sc_ctl[DEPTH].last;
    assign dv_ctl[0].neg   = sum_neg;
    assign dv_rem[0]       = '0;
    assign dv_mq[0]        = sum_neg ? MAG_W'(-sc_sum[DEPTH]) : MAG_W'(sc_sum[DEPTH]);

    generate
        for (gi = 0; gi < MAG_W; gi++)
        begin : g_div
            cma_div_cell #(
                .MAG_W (MAG_W),
                .DIV_W (SEEN_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .divisor (divisor),
                .ctl_in  (dv_ctl[gi]),
                .rem_in  (dv_rem[gi]),
                .mq_in   (dv_mq[gi]),
                .ctl_out (dv_ctl[gi+1]),
                .rem_out (dv_rem[gi+1]),
                .mq_out  (dv_mq[gi+1])
            );
        end
    endgenerate

    // ---------------------------------------------------------------------
    // Sign restore, saturation and output register
    // ---------------------------------------------------------------------
    logic [MAG_W-1:0]  quot;
    logic [SB-1:0]     avg_next;
    logic              out_valid_reg;
    logic [SB-1:0]     avg_reg;
    logic              last_reg;

    assign quot = dv_mq[MAG_W];

    always_comb
    begin
        if (dv_ctl[MAG_W].neg)
        begin
            avg_next = (quot > NEG_LIM) ? SAT_MIN : SB'(-quot[SB-1:0]);
        end
        else
        begin
            avg_next = (quot > POS_LIM) ? SAT_MAX : quot[SB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_ctl[MAG_W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && dv_ctl[MAG_W].valid)
        begin
            avg_reg  <= avg_next;
            last_reg <= dv_ctl[MAG_W].last;
        end
    end

    assign average_ch.valid      = out_valid_reg;
    assign average_ch.average    = $signed(avg_reg);
    assign average_ch.block_last = last_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // a launched request must show up in the chain
    a_launch_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAUNCH && adv) |=> chain_busy)
        else $error("launched request missing from accumulation chain");

    // a window centre never lies behind the newest sample by more than half
    a_centre_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAUNCH) |-> (o_reg <= half))
        else $error("window centre beyond half");

    // the final request of a flush is only sent once the block is closed
    a_flush_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAUNCH && adv && sc_ctl[0].last) |-> !in_block_reg)
        else $error("block_last issued while block still open");

    // history must not move while sums are still collecting taps
    a_hist_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_busy || state_reg == ST_LAUNCH) |=> $stable(seen_reg))
        else $error("block count changed during accumulation");

endmodule

`default_nettype wire

>>> verif/centered_moving_average_edge_replicate_tb.sv
// Self-checking testbench for the centred moving average block with edge replication.
`timescale 1ns / 100ps

module centered_moving_average_edge_replicate_tb;

    // Block geometry, kept at the defaults of the top level
    localparam int MAX_HALF    = 16;
    localparam int SAMPLE_BITS = 24;
    localparam int HIST_DEPTH  = 2 * MAX_HALF + 1;

    localparam int CLK_PERIOD  = 20;
    localparam int RAND_ITEMS  = 320;
    // Quiet cycles allowed before a register write or the end of the run:
    // covers the history chain, the accumulation chain and the divider.
    localparam int SETTLE      = 4 * MAX_HALF + 80;
    // Cycles with no request moving on any port before the run is abandoned
    localparam int STALL_LIMIT = 5000;
    localparam int MAX_PRINTS  = 30;

    localparam logic [cma_pkg::APB_AW-1:0] WIN_ADDR =
        cma_pkg::APB_AW'(4 * int'(cma_pkg::REG_WINDOW_SIZE));

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;

    localparam smp_t SMP_MAX = 24'sh7FFFFF;
    localparam smp_t SMP_MIN = 24'sh800000;

    typedef struct packed {
        smp_t average;
        logic block_last;
    } avg_res_t;

    // One row of the directed table. When typed is set the row causes exactly
    // one average, and that average is given here instead of being predicted.
    typedef struct packed {
        logic [cma_pkg::CFG_W-1:0] win;
        smp_t                      sample;
        logic                      blk_end;
        logic                      typed;
        smp_t                      exp_avg;
        logic                      exp_last;
    } stim_row_t;

    localparam int DIR_ROWS = 24;

    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        // window 1 after reset: samples go straight through
        '{6'd1,  SMP_MAX,        1'b0, 1'b1, SMP_MAX,        1'b0},
        '{6'd1,  SMP_MIN,        1'b1, 1'b1, SMP_MIN,        1'b1},
        // block of a single sample
        '{6'd1,  24'sh000000,    1'b1, 1'b1, 24'sh000000,    1'b1},
        // window 0 also passes through
        '{6'd0,  24'sh5A5A5A,    1'b0, 1'b1, 24'sh5A5A5A,    1'b0},
        '{6'd0,  24'shA5A5A5,    1'b1, 1'b1, 24'shA5A5A5,    1'b1},
        // even window sums three samples over two: clamps at both ends
        '{6'd2,  SMP_MAX,        1'b0, 1'b0, 24'sh000000,    1'b0},
        '{6'd2,  SMP_MAX,        1'b0, 1'b1, SMP_MAX,        1'b0},
        '{6'd2,  SMP_MAX,        1'b1, 1'b0, 24'sh000000,    1'b0},
        '{6'd2,  SMP_MIN,        1'b0, 1'b0, 24'sh000000,    1'b0},
        '{6'd2,  SMP_MIN,        1'b1, 1'b0, 24'sh000000,    1'b0},
        // negative sums truncate toward zero
        '{6'd3,  24'shFFFFFF,    1'b0, 1'b0, 24'sh000000,    1'b0},
        '{6'd3,  24'sh000000,    1'b0, 1'b0, 24'sh000000,    1'b0},
        '{6'd3,  24'sh000001,    1'b1, 1'b0, 24'sh000000,    1'b0},
        // widest window, block shorter than half: all output on the last sample
        '{6'd33, 24'sh123456,    1'b0, 1'b0, 24'sh000000,    1'b0},
        '{6'd33, 24'shFEDCBA,    1'b0, 1'b0, 24'sh000000,    1'b0},
        '{6'd33, SMP_MAX,        1'b0, 1'b0, 24'sh000000,    1'b0},
        '{6'd33, SMP_MIN,        1'b1, 1'b0, 24'sh000000,    1'b0},
        // single sample block with a real window
        '{6'd5,  24'sh000100,    1'b1, 1'b0, 24'sh000000,    1'b0},
        '{6'd5,  24'sh010000,    1'b0, 1'b0, 24'sh000000,    1'b0},
        '{6'd5,  24'sh020000,    1'b0, 1'b0, 24'sh000000,    1'b0},
        '{6'd5,  24'sh030000,    1'b0, 1'b0, 24'sh000000,    1'b0},
        // window narrowed in the middle of the open block
        '{6'd4,  24'sh040000,    1'b0, 1'b0, 24'sh000000,    1'b0},
        '{6'd4,  24'sh050000,    1'b1, 1'b0, 24'sh000000,    1'b0},
        // 33 copies of the maximum over 32 saturate
        '{6'd32, SMP_MAX,        1'b1, 1'b1, SMP_MAX,        1'b1}
    };

    logic clk;
    logic rst_n;

    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [cma_pkg::APB_AW-1:0]   paddr;
    logic [cma_pkg::APB_DW-1:0]   pwdata;
    logic [cma_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    cma_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) smp_if ();
    cma_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) avg_if ();

    centered_moving_average_edge_replicate #(
        .MAX_HALF    (MAX_HALF),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_ch  (smp_if),
        .average_ch (avg_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------
    // Smoothing predictor: own copy of the delay line, block state and
    // the window register.
    // ------------------------------------------------------------------
    smp_t                      hist [HIST_DEPTH];
    smp_t                      first_smp;
    int                        seen;
    bit                        blk_open;
    logic [cma_pkg::CFG_W-1:0] win_reg;

    avg_res_t step_results [$];   // averages caused by the latest request
    avg_res_t expected_q [$];     // averages still owed by the block

    int errors;
    int samples_sent;
    int averages_checked;
    int blocks_closed;
    int win_writes;
    int midblock_changes;
    int idle_cycles;

    // Mean of the window centred o samples behind the newest, with the
    // edges replicated. Division truncates toward zero, then clamps.
    function automatic smp_t window_mean(input int o, input int half, input int ws);
        longint acc;
        longint q;
        int     d;
        acc = 0;
        for (d = o - half; d <= o + half; d++)
        begin
            if (d < 0)
                acc += hist[0];
            else if (d >= seen || d >= HIST_DEPTH)
                acc += first_smp;
            else
                acc += hist[d];
        end
        q = acc / ws;
        if (q > longint'(SMP_MAX))
            q = SMP_MAX;
        if (q < longint'(SMP_MIN))
            q = SMP_MIN;
        return smp_t'(q);
    endfunction

    task automatic predict_sample(input smp_t s, input logic blk_end);
        int ws;
        int half;
        int top;
        int i;
        int o;
        step_results.delete();
        if (!blk_open)
        begin
            first_smp = s;
            seen      = 0;
            blk_open  = 1'b1;
        end
        for (i = HIST_DEPTH - 1; i > 0; i--)
            hist[i] = hist[i-1];
        hist[0] = s;
        if (seen < HIST_DEPTH)
            seen++;

        ws = int'(win_reg);
        if (ws > HIST_DEPTH)
            ws = HIST_DEPTH;

        if (ws <= 1)
        begin
            // pass-through, counts still move
            step_results.push_back('{s, blk_end});
            if (blk_end)
            begin
                blk_open = 1'b0;
                seen     = 0;
            end
            return;
        end

        half = ws / 2;
        if (!blk_end)
        begin
            if (seen > half)
                step_results.push_back('{window_mean(half, half, ws), 1'b0});
        end
        else
        begin
            // flush: short blocks give every one of their outputs here
            top = (seen - 1 < half) ? seen - 1 : half;
            for (o = top; o >= 0; o--)
                step_results.push_back('{window_mean(o, half, ws), (o == 0)});
            blk_open = 1'b0;
            seen     = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (errors < MAX_PRINTS)
            $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // APB access, two phases each; pready is sampled at the access edge
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [cma_pkg::APB_AW-1:0] addr,
                             input logic [cma_pkg::APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [cma_pkg::APB_AW-1:0] addr,
                            output logic [cma_pkg::APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait for every owed average, let the chains go quiet, then retune
    // the window and read it back. A request with no average can still be
    // in flight when the queue runs dry, hence the settle pause.
    task automatic set_window(input logic [cma_pkg::CFG_W-1:0] w);
        logic [cma_pkg::APB_DW-1:0] rd;
        // the last sample has been taken: stop offering it
        @(negedge clk);
        smp_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (blk_open)
            midblock_changes++;
        apb_write(WIN_ADDR, cma_pkg::APB_DW'(w));
        win_reg = w;
        win_writes++;
        apb_read(WIN_ADDR, rd);
        if (rd !== cma_pkg::APB_DW'(w))
            report_mismatch("window readback", longint'(rd), longint'(w));
    endtask

    // ------------------------------------------------------------------
    // Sample side: valid rises at a falling edge after the gap and holds
    // until the request is taken at a rising edge.
    // ------------------------------------------------------------------
    task automatic send_sample(input smp_t s, input logic blk_end, input int gap,
                               input bit typed, input avg_res_t typed_res);
        int i;
        repeat (gap)
        begin
            @(negedge clk);
            smp_if.valid <= 1'b0;
        end
        @(negedge clk);
        smp_if.valid     <= 1'b1;
        smp_if.sample    <= s;
        smp_if.block_end <= blk_end;
        do
            @(posedge clk);
        while (!smp_if.ready);
        samples_sent++;
        predict_sample(s, blk_end);
        if (typed)
            expected_q.push_back(typed_res);
        else
            for (i = 0; i < step_results.size(); i++)
                expected_q.push_back(step_results[i]);
    endtask

    // Mostly back to back, some short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5)
            return 0;
        if (r <= 8)
            return $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(20, 50);
        return $urandom_range(4, 10);
    endfunction

    function automatic smp_t pick_sample();
        int          r;
        logic [31:0] raw;
        r   = $urandom_range(0, 9);
        raw = $urandom();
        if (r <= 3)
            return smp_t'(raw[SAMPLE_BITS-1:0]);
        if (r == 4)
            return SMP_MAX;
        if (r == 5)
            return SMP_MIN;
        if (r == 6)
            return raw[31] ? -smp_t'($urandom_range(0, 255)) : smp_t'($urandom_range(0, 255));
        return {{(SAMPLE_BITS-16){raw[15]}}, raw[15:0]};
    endfunction

    // Mostly short blocks; some run past the depth of the delay line
    function automatic int pick_block_len();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5)
            return $urandom_range(1, 8);
        if (r <= 7)
            return $urandom_range(9, 20);
        if (r == 8)
            return $urandom_range(30, 40);
        return 1;
    endfunction

    function automatic logic [cma_pkg::CFG_W-1:0] pick_window();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5)
            return cma_pkg::CFG_W'($urandom_range(2, 9));
        if (r == 6)
            return cma_pkg::CFG_W'($urandom_range(0, 1));
        if (r == 7)
            return cma_pkg::CFG_W'($urandom_range(31, 33));
        return cma_pkg::CFG_W'($urandom_range(0, 33));
    endfunction

    // ------------------------------------------------------------------
    // Average side: ready toggles in bursts, with the odd long stretch
    // held high so the block also runs unthrottled.
    // ------------------------------------------------------------------
    initial
    begin : avg_ready_gen
        int r;
        int run_len;
        int gap_len;
        avg_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 9);
            if (r <= 6)
                run_len = $urandom_range(1, 8);
            else if (r <= 8)
                run_len = $urandom_range(20, 60);
            else
                run_len = $urandom_range(150, 300);
            r = $urandom_range(0, 9);
            if (r <= 6)
                gap_len = $urandom_range(1, 2);
            else if (r <= 8)
                gap_len = $urandom_range(3, 8);
            else
                gap_len = $urandom_range(20, 60);
            @(negedge clk);
            avg_if.ready <= 1'b1;
            repeat (run_len - 1) @(negedge clk);
            @(negedge clk);
            avg_if.ready <= 1'b0;
            repeat (gap_len - 1) @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Checker: every accepted average against the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : avg_check
        avg_res_t want;
        if (rst_n && avg_if.valid && avg_if.ready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected average", longint'(avg_if.average), 0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (avg_if.average !== want.average)
                    report_mismatch("average", longint'(avg_if.average),
                                    longint'(want.average));
                if (avg_if.block_last !== want.block_last)
                    report_mismatch("block_last", longint'(avg_if.block_last),
                                    longint'(want.block_last));
            end
            averages_checked++;
            if (avg_if.block_last === 1'b1)
                blocks_closed++;
        end
    end

    // Watchdog: any request on either channel, or APB traffic, clears it
    always @(posedge clk)
    begin
        if ((smp_if.valid && smp_if.ready) || (avg_if.valid && avg_if.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no request moved for %0d cycles, %0d averages still owed",
                     $time, idle_cycles, expected_q.size());
            $display("centered_moving_average_edge_replicate_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int        row;
        int        blk_left;
        int        phase_len;
        int        i;
        int        total;
        bit        no_idle;
        smp_t      s;
        logic      e;
        stim_row_t cur;

        // every input known from time zero
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        smp_if.valid     = 1'b0;
        smp_if.sample    = '0;
        smp_if.block_end = 1'b0;

        errors           = 0;
        samples_sent     = 0;
        averages_checked = 0;
        blocks_closed    = 0;
        win_writes       = 0;
        midblock_changes = 0;
        idle_cycles      = 0;

        // predictor after reset
        for (i = 0; i < HIST_DEPTH; i++)
            hist[i] = '0;
        first_smp = '0;
        seen      = 0;
        blk_open  = 1'b0;
        win_reg   = cma_pkg::WINDOW_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; the window is retuned only when a row asks for
        // another one, and only once the block has gone idle
        for (row = 0; row < DIR_ROWS; row++)
        begin
            cur = DIR_TABLE[row];
            if (cur.win != win_reg)
                set_window(cur.win);
            send_sample(cur.sample, cur.blk_end, pick_gap(), cur.typed,
                        '{cur.exp_avg, cur.exp_last});
        end

        // random phases: a window per phase, well-formed blocks of random
        // content; a block cut at a phase boundary sees the window change
        total    = 0;
        blk_left = 0;
        while (total < RAND_ITEMS)
        begin
            set_window(pick_window());
            phase_len = $urandom_range(10, 40);
            no_idle   = ($urandom_range(0, 4) == 0);
            for (i = 0; i < phase_len; i++)
            begin
                if (blk_left == 0)
                    blk_left = pick_block_len();
                s = pick_sample();
                e = (blk_left == 1);
                blk_left--;
                send_sample(s, e, no_idle ? 0 : pick_gap(), 1'b0, '0);
                total++;
                // hold the sender back until the block has caught up
                if ($urandom_range(0, 39) == 0)
                begin
                    @(negedge clk);
                    smp_if.valid <= 1'b0;
                    while (expected_q.size() != 0)
                        @(posedge clk);
                end
            end
        end

        @(negedge clk);
        smp_if.valid <= 1'b0;

        // drain, then give stragglers time to show up
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d samples over %0d window settings (%0d changed inside a block)",
                 samples_sent, win_writes, midblock_changes);
        $display("Checked %0d averages across %0d closed blocks, %0d mismatches",
                 averages_checked, blocks_closed, errors);
        if (errors == 0)
            $display("centered_moving_average_edge_replicate_tb: PASS");
        else
            $display("centered_moving_average_edge_replicate_tb: FAIL");
        $finish;
    end

endmodule
